// ----- hdl/annexb_to_length_prefix_patcher_defines.svh -----
// Assertion macros used by the byte-stream patcher top level.
`ifndef ANNEXB_TO_LENGTH_PREFIX_PATCHER_DEFINES_SVH
`define ANNEXB_TO_LENGTH_PREFIX_PATCHER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ABLP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define ABLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ablp_pkg.sv -----
// Types, constants and codes shared by the byte-stream patcher modules.
`timescale 1ns / 1ps
`default_nettype none

package ablp_pkg;

   localparam int unsigned POSITION_WIDTH_DEFAULT = 24;
   localparam int unsigned FIELD_WIDTH            = 24;
   localparam int unsigned BYTE_WIDTH             = 8;
   localparam int unsigned WINDOW_BITS            = 56;
   localparam int unsigned TYPE_WIDTH             = 6;
   localparam int unsigned UNIT_TYPE_BITS         = 5;
   localparam int unsigned LENGTH_BYTES           = 4;
   localparam int unsigned MAX_RECORDS            = 4;
   localparam int unsigned COUNT_WIDTH            = $clog2(MAX_RECORDS + 1);
   localparam int unsigned REC_IDX_WIDTH          = $clog2(MAX_RECORDS);
   localparam int unsigned QUEUE_DEPTH            = 4;
   localparam int unsigned CSR_INDEX_WIDTH        = 1;

   localparam logic [31:0] SYNC_PATTERN = 32'h0000_0001;

   localparam logic [TYPE_WIDTH-1:0] TYPE_SPS  = TYPE_WIDTH'(7);
   localparam logic [TYPE_WIDTH-1:0] TYPE_PPS  = TYPE_WIDTH'(8);
   localparam logic [TYPE_WIDTH-1:0] TYPE_NONE = TYPE_WIDTH'(63);

   typedef enum logic [1:0] {
      KIND_PATCH = 2'd0,
      KIND_TRIM  = 2'd1,
      KIND_DELTA = 2'd2,
      KIND_END   = 2'd3
   } record_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SINGLE_NAL_MODE = 1'b0,
      CSR_HEADER_BYTES    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  last_byte;
   } req_type;

   typedef struct packed {
      record_kind_type        record_kind;
      logic [FIELD_WIDTH-1:0] byte_offset;
      logic [FIELD_WIDTH-1:0] record_value;
      logic                   run_end;
   } rsp_type;

   typedef struct packed {
      logic                   single_nal_mode;
      logic [FIELD_WIDTH-1:0] header_bytes;
   } cfg_type;

   typedef struct packed {
      record_kind_type        kind;
      logic [FIELD_WIDTH-1:0] offset;
      logic [FIELD_WIDTH-1:0] value;
   } edit_type;

   // Records caused by one request, packed from slot zero.
   typedef struct packed {
      edit_type [MAX_RECORDS-1:0] recs;
      logic [COUNT_WIDTH-1:0]     count;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- hdl/ablp_front.sv -----
// Front end: accepts request bytes, detects start codes and builds record bundles.
`timescale 1ns / 1ps
`default_nettype none

module ablp_front #(
   parameter int unsigned POSITION_WIDTH = ablp_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ablp_pkg::req_type        req_data,
   input  ablp_pkg::cfg_type        cfg,
   input  ablp_pkg::queue_status_type q_status,
   output logic                     push,
   output ablp_pkg::bundle_type     push_bundle
);
   import ablp_pkg::*;

   localparam int unsigned PW    = POSITION_WIDTH;
   localparam int unsigned SUM_W = ((PW > FIELD_WIDTH) ? PW : FIELD_WIDTH) + 2;
   localparam int unsigned EXT_W = ((PW + 1) > FIELD_WIDTH) ? (PW + 1) : FIELD_WIDTH;

   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [PW:0]            mark_ff, mark_in;
   logic [TYPE_WIDTH-1:0]  cur_type_ff, cur_type_in;
   logic                   single_done_ff, single_done_in;

   logic [WINDOW_BITS+BYTE_WIDTH-1:0] win_full;
   logic                   accept;
   logic                   sc_hit;
   logic [TYPE_WIDTH-1:0]  unit_type;
   logic                   unit_is_ps;
   logic                   prev_is_ps;
   logic                   prev_none;
   logic [PW-1:0]          pos_i;
   logic [PW:0]            size;
   logic [SUM_W-1:0]       mark_sum;
   logic [SUM_W-1:0]       mark_limit;
   logic [PW:0]            mark_next;
   logic [TYPE_WIDTH-1:0]  type_next;
   logic                   done_next;
   edit_type [MAX_RECORDS-1:0] cand;
   logic [MAX_RECORDS-1:0] cand_v;
   logic [COUNT_WIDTH-1:0] fill_idx;

   // Keep the low field bits of a position-width quantity.
   function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [EXT_W-1:0] x);
      return x[FIELD_WIDTH-1:0];
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !q_status.full;

   // Classify the window: start code in the oldest four bytes, type byte after it.
   assign win_full   = {window_ff, req_data.data_byte};
   assign sc_hit     = !single_done_ff &&
                       (win_full[WINDOW_BITS+BYTE_WIDTH-1 -: 32] == SYNC_PATTERN);
   assign unit_type  = TYPE_WIDTH'(win_full[24 +: UNIT_TYPE_BITS]);
   assign unit_is_ps = (unit_type == TYPE_SPS) || (unit_type == TYPE_PPS);
   assign prev_is_ps = (cur_type_ff == TYPE_SPS) || (cur_type_ff == TYPE_PPS);
   assign prev_none  = (cur_type_ff == TYPE_NONE);
   assign pos_i      = pos_ff - PW'(LENGTH_BYTES);
   assign size       = {1'b0, pos_ff} + (PW+1)'(1);
   assign mark_sum   = SUM_W'(pos_i) + SUM_W'(cfg.header_bytes) + SUM_W'(1);
   assign mark_limit = SUM_W'(1) << PW;

   // Build candidate records in emission order.
   always_comb begin
      cand      = '0;
      cand_v    = '0;
      mark_next = mark_ff;
      type_next = cur_type_ff;
      done_next = single_done_ff;
      if (sc_hit) begin
         type_next = unit_type;
         if (cfg.single_nal_mode) begin
            done_next = 1'b1;
            cand_v[0]      = 1'b1;
            cand[0].kind   = KIND_DELTA;
            if (unit_is_ps) begin
               cand[0].value  = '0;
               cand_v[1]      = 1'b1;
               cand[1].kind   = KIND_TRIM;
               cand[1].offset = cfg.header_bytes;
               mark_next = (mark_sum > mark_limit) ? (PW+1)'(mark_limit)
                                                   : (PW+1)'(mark_sum);
            end else begin
               cand[0].value = FIELD_WIDTH'(1);
               mark_next     = {1'b0, pos_i} + (PW+1)'(1);
            end
         end else begin
            if (prev_is_ps) begin
               cand_v[0]      = 1'b1;
               cand[0].kind   = KIND_TRIM;
               cand[0].offset = to_field(EXT_W'(pos_i - PW'(3)));
               cand_v[1]      = 1'b1;
               cand[1].kind   = KIND_DELTA;
            end else if (!prev_none) begin
               cand_v[0]      = 1'b1;
               cand[0].kind   = KIND_PATCH;
               cand[0].offset = to_field(EXT_W'(mark_ff[PW-1:0] - PW'(LENGTH_BYTES)));
               cand[0].value  = to_field(EXT_W'(pos_i - mark_ff[PW-1:0] - PW'(3)));
            end
            mark_next = {1'b0, pos_i} + (PW+1)'(1);
         end
      end
      // Close the buffer: final length patch unless its mark lies past the end.
      if (req_data.last_byte) begin
         if ((type_next != TYPE_NONE) && (mark_next <= size)) begin
            cand_v[2]      = 1'b1;
            cand[2].kind   = KIND_PATCH;
            cand[2].offset = to_field(EXT_W'(mark_next[PW-1:0] - PW'(LENGTH_BYTES)));
            cand[2].value  = to_field(EXT_W'(size - mark_next));
         end
         cand_v[3]      = 1'b1;
         cand[3].kind   = KIND_END;
         cand[3].value  = to_field(EXT_W'(size));
      end
   end

   // Pack the valid candidates into consecutive slots.
   always_comb begin
      push_bundle = '0;
      fill_idx    = '0;
      for (int k = 0; k < MAX_RECORDS; k++) begin
         if (cand_v[k]) begin
            push_bundle.recs[fill_idx[REC_IDX_WIDTH-1:0]] = cand[k];
            fill_idx = fill_idx + COUNT_WIDTH'(1);
         end
      end
      push_bundle.count = fill_idx;
   end

   assign push = accept && (push_bundle.count != '0);

   // Advance scan state, or clear it after the last byte.
   always_comb begin
      window_in      = window_ff;
      pos_in         = pos_ff;
      mark_in        = mark_ff;
      cur_type_in    = cur_type_ff;
      single_done_in = single_done_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            window_in      = '1;
            pos_in         = '0;
            mark_in        = '0;
            cur_type_in    = TYPE_NONE;
            single_done_in = 1'b0;
         end else begin
            window_in      = win_full[WINDOW_BITS-1:0];
            pos_in         = pos_ff + PW'(1);
            mark_in        = mark_next;
            cur_type_in    = type_next;
            single_done_in = done_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '1;
         pos_ff         <= '0;
         mark_ff        <= '0;
         cur_type_ff    <= TYPE_NONE;
         single_done_ff <= 1'b0;
      end else begin
         window_ff      <= window_in;
         pos_ff         <= pos_in;
         mark_ff        <= mark_in;
         cur_type_ff    <= cur_type_in;
         single_done_ff <= single_done_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ablp_queue.sv -----
// Bundle queue between the front end and the record emitter.
`timescale 1ns / 1ps
`default_nettype none

module ablp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ablp_pkg::bundle_type       push_bundle,
   input  logic                       pop,
   output ablp_pkg::bundle_type       head,
   output ablp_pkg::queue_status_type q_status
);
   import ablp_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store bundles.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ablp_back.sv -----
// Back end: unpacks queued bundles into records, one per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module ablp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ablp_pkg::bundle_type       head,
   input  ablp_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ablp_pkg::rsp_type          rsp_data
);
   import ablp_pkg::*;

   logic [REC_IDX_WIDTH-1:0] sub_ff, sub_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic                     load;
   logic                     is_last;
   edit_type                 cur;

   // Load a queued record when the output register is empty or draining.
   assign load    = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign cur     = head.recs[sub_ff];
   assign is_last = ((COUNT_WIDTH'(sub_ff) + COUNT_WIDTH'(1)) == head.count);
   assign pop     = load && is_last;

   always_comb begin
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.record_kind  = cur.kind;
         rsp_data_in.byte_offset  = cur.offset;
         rsp_data_in.record_value = cur.value;
         rsp_data_in.run_end      = is_last;
         sub_in = is_last ? '0 : sub_ff + REC_IDX_WIDTH'(1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the record payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/annexb_to_length_prefix_patcher.sv -----
// The first record of a request goes through the bundle queue, then the output register.
// Throughput: one request byte per cycle; records leave one per cycle while rsp_ready is high.
// A request stalls only while the four-entry bundle queue is full (up to four records a byte).
// Reset (synchronous, active high) clears scan state, queue, output valid and both registers.
// Scan state also returns to its reset values after each last byte of a buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "annexb_to_length_prefix_patcher_defines.svh"

module annexb_to_length_prefix_patcher #(
   parameter int unsigned POSITION_WIDTH = ablp_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  ablp_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output ablp_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_we,
   input  logic [ablp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ablp_pkg::FIELD_WIDTH-1:0]        csr_wdata
);
   import ablp_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   bundle_type       push_bundle;
   bundle_type       head;
   logic             push;
   logic             pop;

   // Decode configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SINGLE_NAL_MODE: cfg_in.single_nal_mode = csr_wdata[0];
            CSR_HEADER_BYTES:    cfg_in.header_bytes    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ablp_front #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .push        (push),
      .push_bundle (push_bundle)
   );

   ablp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .q_status    (q_status)
   );

   ablp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ABLP_ASSERT_SAME(a_queue_state, q_status.full, !q_status.empty, "queue full and empty")
   `ABLP_ASSERT_SAME(a_end_closes_run, rsp_valid && (rsp_data.record_kind == KIND_END), rsp_data.run_end, "end record not last of run")
   `ABLP_ASSERT_NEXT(a_last_queues, req_valid && req_ready && req_data.last_byte, !q_status.empty, "last byte left no bundle")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the byte-stream to length-prefix patcher.
`timescale 1ns / 1ps

module testbench;
   import ablp_pkg::*;

   localparam int unsigned POS_W        = POSITION_WIDTH_DEFAULT;
   localparam bit [63:0]   POS_SPAN     = 64'd1 << POS_W;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned PHASE_BYTES  = 14;

   // Predict the edit records of each request byte and match them in order.
   class edit_record_scoreboard;
      logic [WINDOW_BITS-1:0] window;
      logic [POS_W-1:0]       position;
      logic [TYPE_WIDTH-1:0]  cur_unit;
      logic [TYPE_WIDTH-1:0]  prev_unit;
      bit [63:0]              mark;
      bit                     scan_off;
      bit                     single_mode;
      logic [FIELD_WIDTH-1:0] header_len;
      rsp_type                fresh_edits[$];
      rsp_type                pending_edits[$];
      int unsigned            errors;
      int unsigned            bytes_seen;
      int unsigned            buffers_seen;
      int unsigned            edits_predicted;
      int unsigned            kind_hits[4];

      function new();
         clear_scan();
         single_mode = 1'b0;
         header_len = '0;
         errors = 0;
         bytes_seen = 0;
         buffers_seen = 0;
         edits_predicted = 0;
         foreach (kind_hits[k]) kind_hits[k] = 0;
      endfunction

      // Return scan state to its values at the start of a buffer.
      function void clear_scan();
         window = '1;
         position = '0;
         cur_unit = TYPE_NONE;
         prev_unit = TYPE_NONE;
         mark = '0;
         scan_off = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, logic [FIELD_WIDTH-1:0] value);
         case (idx)
            CSR_SINGLE_NAL_MODE: single_mode = value[0];
            CSR_HEADER_BYTES:    header_len = value;
            default: ;
         endcase
      endfunction

      function void add_edit(record_kind_type kind, bit [63:0] offset, bit [63:0] value);
         rsp_type r;
         r.record_kind = kind;
         r.byte_offset = offset[FIELD_WIDTH-1:0];
         r.record_value = value[FIELD_WIDTH-1:0];
         r.run_end = 1'b0;
         fresh_edits.push_back(r);
      endfunction

      function void note_request(req_type req);
         logic [63:0]           w;
         logic [POS_W-1:0]      p;
         logic [POS_W-1:0]      code_pos;
         logic [TYPE_WIDTH-1:0] t;
         bit [63:0]             size;
         bit [63:0]             m;
         fresh_edits.delete();
         w = {window, req.data_byte};
         p = position;
         bytes_seen++;
         // act on a start code once the fourth byte after its 01 arrives
         if (!scan_off && w[63:32] == SYNC_PATTERN) begin
            code_pos = p - POS_W'(4);
            t = TYPE_WIDTH'(w[28:24]);
            prev_unit = cur_unit;
            cur_unit = t;
            if (single_mode) begin
               if (t == TYPE_SPS || t == TYPE_PPS) begin
                  add_edit(KIND_DELTA, 0, 0);
                  add_edit(KIND_TRIM, header_len, 0);
                  m = 64'(code_pos) + 64'(header_len) + 64'd1;
                  mark = (m > POS_SPAN) ? POS_SPAN : m;
               end else begin
                  add_edit(KIND_DELTA, 0, 1);
                  mark = 64'(code_pos) + 64'd1;
               end
               scan_off = 1'b1;
            end else begin
               if (prev_unit == TYPE_SPS || prev_unit == TYPE_PPS) begin
                  add_edit(KIND_TRIM, 64'(code_pos) - 64'd3, 0);
                  add_edit(KIND_DELTA, 0, 0);
               end else if (prev_unit != TYPE_NONE) begin
                  add_edit(KIND_PATCH, mark - 64'd4, 64'(code_pos) - mark - 64'd3);
               end
               mark = 64'(code_pos) + 64'd1;
            end
         end
         // close the buffer: final patch unless its mark lies past the end
         if (req.last_byte) begin
            size = 64'(p) + 64'd1;
            if (cur_unit != TYPE_NONE && mark <= size)
               add_edit(KIND_PATCH, mark - 64'd4, size - mark);
            add_edit(KIND_END, 0, size);
            buffers_seen++;
            clear_scan();
         end else begin
            window = w[WINDOW_BITS-1:0];
            position = p + 1'b1;
         end
         if (fresh_edits.size() > 0) fresh_edits[fresh_edits.size()-1].run_end = 1'b1;
         foreach (fresh_edits[k]) pending_edits.push_back(fresh_edits[k]);
         edits_predicted += fresh_edits.size();
      endfunction

      function void check_edit(rsp_type got);
         rsp_type want;
         if (pending_edits.size() == 0) begin
            $error("unexpected record: kind %0d offset %0d value %0d run_end %0d",
                   got.record_kind, got.byte_offset, got.record_value, got.run_end);
            errors++;
            return;
         end
         want = pending_edits.pop_front();
         kind_hits[int'(want.record_kind)]++;
         if (got.record_kind !== want.record_kind) begin
            $error("record_kind: expected %0d, got %0d", want.record_kind, got.record_kind);
            errors++;
         end
         if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
            errors++;
         end
         if (got.record_value !== want.record_value) begin
            $error("record_value: expected %0d, got %0d", want.record_value,
                   got.record_value);
            errors++;
         end
         if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return pending_edits.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_type                    rsp_data;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [FIELD_WIDTH-1:0]     csr_wdata;

   edit_record_scoreboard  records;
   logic [BYTE_WIDTH-1:0]  stream_bytes[$];
   int unsigned            send_gap_pct;
   int unsigned            recv_gap_pct;
   bit                     hold_request;
   int unsigned            quiet_cycles;

   annexb_to_length_prefix_patcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Zero-heavy so that partial and accidental start codes turn up.
   function automatic logic [BYTE_WIDTH-1:0] random_byte();
      return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
   endfunction

   // Offer one request, idling first at random, and hold it until accepted.
   task automatic send_request(logic [BYTE_WIDTH-1:0] data, logic last);
      req_type req;
      req.data_byte = data;
      req.last_byte = last;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (!req_ready);
      records.note_request(req);
   endtask

   task automatic send_stream(bit closes_buffer);
      foreach (stream_bytes[k])
         send_request(stream_bytes[k], closes_buffer && k == stream_bytes.size() - 1);
   endtask

   // Drop valid and wait until every predicted record has come back.
   task automatic drain_records();
      req_valid <= 1'b0;
      while (records.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(bit mode, logic [FIELD_WIDTH-1:0] hdr);
      csr_we <= 1'b1;
      csr_index <= CSR_SINGLE_NAL_MODE;
      csr_wdata <= FIELD_WIDTH'(mode);
      @(posedge clock);
      records.write_reg(CSR_SINGLE_NAL_MODE, FIELD_WIDTH'(mode));
      csr_index <= CSR_HEADER_BYTES;
      csr_wdata <= hdr;
      @(posedge clock);
      records.write_reg(CSR_HEADER_BYTES, hdr);
      csr_we <= 1'b0;
   endtask

   // Build one buffer: mostly start-code-led units, some noise, some cut short.
   task automatic build_random_buffer();
      int unsigned           shape;
      logic [UNIT_TYPE_BITS-1:0] t;
      stream_bytes.delete();
      shape = $urandom_range(99);
      if (shape < 12) begin
         repeat ($urandom_range(1, 12)) stream_bytes.push_back(random_byte());
      end else begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(9) == 0) stream_bytes.push_back(random_byte());
            // occasionally a three-byte start code
            if ($urandom_range(7) != 0) stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h01);
            case ($urandom_range(9))
               0, 1, 2: t = TYPE_SPS[UNIT_TYPE_BITS-1:0];
               3, 4:    t = TYPE_PPS[UNIT_TYPE_BITS-1:0];
               default: t = UNIT_TYPE_BITS'($urandom);
            endcase
            stream_bytes.push_back({3'($urandom), t});
            repeat ($urandom_range(0, 6)) stream_bytes.push_back(random_byte());
         end
         if (shape < 25)
            stream_bytes = stream_bytes[0:$urandom_range(0, stream_bytes.size() - 1)];
      end
   endtask

   // Receive records, stalling at random, with one long hold-off on request.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) records.check_edit(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      records = new();
      hold_request = 1'b0;
      quiet_cycles = 0;
      send_gap_pct = 18;
      recv_gap_pct = 72;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SINGLE_NAL_MODE;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: short buffer, one-byte buffer, then SPS, PPS and a slice in one buffer
      stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
      send_stream(1'b1);
      stream_bytes = '{8'hff};
      send_stream(1'b1);
      stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01,
                       8'h68, 8'haa, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h80, 8'h7f,
                       8'hff};
      send_stream(1'b1);

      // Random phases, each with its own register setting and idling pattern
      for (int phase = 0; phase < 6; phase++) begin
         int unsigned            phase_bytes;
         int unsigned            phase_limit;
         bit                     mode;
         logic [FIELD_WIDTH-1:0] hdr;
         drain_records();
         case (phase)
            0: begin mode = 1'b0; hdr = '0; end
            1: begin mode = 1'b1; hdr = '1; end
            2: begin mode = 1'b0; hdr = FIELD_WIDTH'($urandom); end
            3: begin mode = 1'b1; hdr = FIELD_WIDTH'($urandom_range(0, 12)); end
            4: begin mode = 1'b1; hdr = '0; end
            default: begin mode = 1'b0; hdr = FIELD_WIDTH'($urandom); end
         endcase
         program_regs(mode, hdr);
         send_gap_pct = (phase < 2) ? 18 : (phase < 4) ? 72 : 0;
         recv_gap_pct = (phase < 2) ? 72 : (phase < 4) ? 18 : 0;
         // hold the receiver off while the sender keeps going, to back up the queue
         if (phase == 4) hold_request = 1'b1;
         // send longer during the hold so that enough bundles pile up
         phase_limit = (phase == 4) ? 3 * PHASE_BYTES : PHASE_BYTES;
         phase_bytes = 0;
         while (phase_bytes < phase_limit) begin
            build_random_buffer();
            send_stream(1'b1);
            phase_bytes += stream_bytes.size();
         end
      end

      // Mode changes inside one buffer: multi, then single, then multi again
      drain_records();
      program_regs(1'b0, FIELD_WIDTH'(5));
      stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h11, 8'h22, 8'h33};
      send_stream(1'b0);
      drain_records();
      program_regs(1'b1, FIELD_WIDTH'(5));
      stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h44, 8'h55, 8'h66, 8'h77};
      send_stream(1'b0);
      drain_records();
      program_regs(1'b0, FIELD_WIDTH'(5));
      stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h61, 8'h9a, 8'hbc, 8'hde, 8'hf0};
      send_stream(1'b1);

      drain_records();
      $display("Checked %0d bytes in %0d buffers: %0d patch, %0d trim, %0d delta, %0d end.",
               records.bytes_seen, records.buffers_seen, records.kind_hits[KIND_PATCH],
               records.kind_hits[KIND_TRIM], records.kind_hits[KIND_DELTA],
               records.kind_hits[KIND_END]);
      $display(
         "Covered both modes, zero and full headers, mode changes mid-buffer, a long stall.");
      if (records.errors == 0 && records.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
